// File: rtl/core/colon_hash_command_framer_assert.svh
// Assertion macros for the command framer checks.
`ifndef COLON_HASH_COMMAND_FRAMER_ASSERT_SVH
`define COLON_HASH_COMMAND_FRAMER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define CHCF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define CHCF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/chcf_pkg.sv
// Shared constants for the colon/hash command framer.
`timescale 1ns / 1ps

package chcf_pkg;

	localparam int unsigned MAX_FILL_DEF = 31;

	localparam logic [7:0] CH_START = 8'h3A;
	localparam logic [7:0] CH_END   = 8'h23;
	localparam logic [7:0] CH_ACK   = 8'h06;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;

endpackage

// File: rtl/core/chcf_if.sv
// Valid/ready channel interfaces for received bytes and command results.
`timescale 1ns / 1ps

interface chcf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface chcf_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_data;
	logic       is_ack;
	logic       last;

	modport source (output valid, output out_byte, output has_data, output is_ack,
		output last, input ready);
	modport sink (input valid, input out_byte, input has_data, input is_ack,
		input last, output ready);
endinterface

// File: rtl/core/colon_hash_command_framer.sv
// Top level of the colon/hash command framer.
//
//  channel | dir | payload                              | transfer
//  rx      | in  | rx_byte                              | valid & ready
//  res     | out | out_byte, has_data, is_ack, last     | valid & ready
//
// A plain or skipped byte stays in IDLE; an ACK reply is loaded in the same cycle.
// A valid frame end drains its payload through the store read port: each slot
// read goes through S_FETCH, then S_EVAL (check); the held final byte is sent
// from S_TAIL when the run reaches the last slot with more than one byte.
// rx is held off while a payload drains and while the result register is full
// and not being taken. arst_n clears the fill count, state and result valid flag.
`timescale 1ns / 1ps

module colon_hash_command_framer #(
	parameter int unsigned MAX_FILL = chcf_pkg::MAX_FILL_DEF
) (
	input logic        clk,
	input logic        arst_n,
	chcf_rx_if.sink    rx,
	chcf_res_if.source res
);

	localparam int unsigned DEPTH = MAX_FILL + 1;
	localparam int unsigned AW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FETCH = 4'b0010,
		S_EVAL  = 4'b0100,
		S_TAIL  = 4'b1000
	} state_t;

	state_t        state_q, state_nx;
	logic [AW-1:0] fill_q, fill_nx;
	logic [AW-1:0] fill_inc;
	logic          start_ok_q, start_ok_nx;
	logic          tail_end_q, tail_end_nx;
	logic [AW-1:0] idx_q, idx_nx;
	logic [AW-1:0] last_idx_q, last_idx_nx;
	logic [7:0]    cur_q, cur_nx;
	logic          have_cur_q, have_cur_nx;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          has_data_q, is_ack_q, last_q;

	logic          ld;
	logic [7:0]    ld_byte;
	logic          ld_data, ld_ack, ld_last;

	logic          slot_free, acc, is_skip, ack_now, store_en, is_full, is_end, frame_ok;
	logic [7:0]    c;
	logic [7:0]    rd_data;
	logic          rd_en;
	logic          d_zero, at_end;

	assign c         = rx.rx_byte;
	assign slot_free = !out_valid_q || res.ready;
	assign rx.ready  = (state_q == S_IDLE) && slot_free;
	assign acc       = rx.valid && rx.ready;
	assign is_skip   = (c == chcf_pkg::CH_SPACE) || (c == chcf_pkg::CH_LF) ||
		(c == chcf_pkg::CH_CR) || (c == chcf_pkg::CH_ACK);
	assign ack_now   = (c == chcf_pkg::CH_ACK) && (fill_q == '0);
	assign store_en  = acc && !is_skip;
	assign is_full   = (fill_q == AW'(MAX_FILL));
	assign fill_inc  = is_full ? fill_q : fill_q + 1'b1;
	assign is_end    = (c == chcf_pkg::CH_END);
	assign frame_ok  = (fill_inc > AW'(1)) && start_ok_q && (!is_full || tail_end_q);

	assign rd_en  = (state_q == S_FETCH);
	assign d_zero = (rd_data == chcf_pkg::CH_NUL);
	assign at_end = (idx_q == last_idx_q);

	chcf_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (store_en),
		.wr_addr(fill_q),
		.wr_data(c),
		.rd_en  (rd_en),
		.rd_addr(idx_q),
		.rd_data(rd_data)
	);

	always_comb begin
		state_nx    = state_q;
		fill_nx     = fill_q;
		start_ok_nx = start_ok_q;
		tail_end_nx = tail_end_q;
		idx_nx      = idx_q;
		last_idx_nx = last_idx_q;
		cur_nx      = cur_q;
		have_cur_nx = have_cur_q;
		ld          = 1'b0;
		ld_byte     = chcf_pkg::CH_NUL;
		ld_data     = 1'b0;
		ld_ack      = 1'b0;
		ld_last     = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (acc && ack_now) begin
					ld      = 1'b1;
					ld_byte = chcf_pkg::CH_ACK;
					ld_data = 1'b1;
					ld_ack  = 1'b1;
				end else if (store_en) begin
					if (fill_q == '0) begin
						start_ok_nx = (c == chcf_pkg::CH_START);
					end
					if (fill_q == AW'(MAX_FILL - 1)) begin
						tail_end_nx = is_end;
					end
					if (is_end) begin
						fill_nx = '0;
						if (frame_ok) begin
							if (fill_inc == AW'(2)) begin
								ld = 1'b1;
							end else begin
								idx_nx      = AW'(1);
								last_idx_nx = fill_inc - AW'(2);
								have_cur_nx = 1'b0;
								state_nx    = S_FETCH;
							end
						end
					end else begin
						fill_nx = fill_inc;
					end
				end
			end
			S_FETCH: begin
				state_nx = S_EVAL;
			end
			S_EVAL: begin
				if (slot_free) begin
					if (!have_cur_q) begin
						if (d_zero) begin
							ld       = 1'b1;
							state_nx = S_IDLE;
						end else if (at_end) begin
							ld       = 1'b1;
							ld_byte  = rd_data;
							ld_data  = 1'b1;
							state_nx = S_IDLE;
						end else begin
							cur_nx      = rd_data;
							have_cur_nx = 1'b1;
							idx_nx      = idx_q + 1'b1;
							state_nx    = S_FETCH;
						end
					end else begin
						ld      = 1'b1;
						ld_byte = cur_q;
						ld_data = 1'b1;
						if (d_zero) begin
							state_nx = S_IDLE;
						end else begin
							ld_last = 1'b0;
							cur_nx  = rd_data;
							if (at_end) begin
								state_nx = S_TAIL;
							end else begin
								idx_nx   = idx_q + 1'b1;
								state_nx = S_FETCH;
							end
						end
					end
				end
			end
			S_TAIL: begin
				if (slot_free) begin
					ld       = 1'b1;
					ld_byte  = cur_q;
					ld_data  = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			have_cur_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_nx;
			fill_q     <= fill_nx;
			have_cur_q <= have_cur_nx;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		start_ok_q <= start_ok_nx;
		tail_end_q <= tail_end_nx;
		idx_q      <= idx_nx;
		last_idx_q <= last_idx_nx;
		cur_q      <= cur_nx;
		if (ld) begin
			out_byte_q <= ld_byte;
			has_data_q <= ld_data;
			is_ack_q   <= ld_ack;
			last_q     <= ld_last;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.out_byte = out_byte_q;
	assign res.has_data = has_data_q;
	assign res.is_ack   = is_ack_q;
	assign res.last     = last_q;

endmodule

// File: rtl/core/chcf_store.sv
// Frame byte store: one write port, one read port with registered data.
`timescale 1ns / 1ps

module chcf_store #(
	parameter int unsigned DEPTH = chcf_pkg::MAX_FILL_DEF + 1,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/chcf_checker.sv
// Port-level checks for the command framer, bound to the top level.
`timescale 1ns / 1ps
`include "colon_hash_command_framer_assert.svh"

module chcf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] out_byte,
	input logic       has_data,
	input logic       is_ack,
	input logic       last
);

	`CHCF_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(out_byte) && $stable(last), "result changed while stalled")
	`CHCF_ASSERT_IMP(a_ack_form, res_valid && is_ack, (out_byte == chcf_pkg::CH_ACK) && has_data && last, "malformed acknowledge result")
	`CHCF_ASSERT_IMP(a_empty_form, res_valid && !has_data, (out_byte == chcf_pkg::CH_NUL) && last && !is_ack, "malformed empty command")
	`CHCF_ASSERT_IMP(a_data_nonzero, res_valid && has_data, out_byte != chcf_pkg::CH_NUL, "zero byte in payload")
	`CHCF_ASSERT_IMP(a_no_rx_mid_run, res_valid && !last, !rx_ready, "byte taken in the middle of a run")

endmodule

bind colon_hash_command_framer chcf_checker u_chcf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rx_ready (rx.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.out_byte (res.out_byte),
	.has_data (res.has_data),
	.is_ack   (res.is_ack),
	.last     (res.last)
);
